@@ rtl/atu_pkg.sv @@
`default_nettype none
package atu_pkg;

  // Table geometry and reset value of the target register
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [6:0]  ACK_TARGET_RESET = 7'd20;

  // Operation codes
  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_FIND = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msg_id;
    logic [6:0]  start_pos;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_pos;
    logic [31:0] entry_id;
    logic [6:0]  acked_count;
    logic [6:0]  entry_count;
    logic        done_res;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // latch a new item, set up the scan
    logic scan_step;  // issue next read, check previous one
    logic capture;    // record the scan outcome
    logic finish;     // update table and counts, load the result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic needs_scan; // item at the input is an ack or a find
    logic hit;        // checked entry satisfies the scan
    logic exhausted;  // nothing left to check
    logic out_free;   // result register can take a new item
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/atu_ram.sv @@
`default_nettype none
module atu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/atu_ctrl.sv @@
`default_nettype none
module atu_ctrl
  import atu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.needs_scan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.exhausted) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/atu_dp.sv @@
`default_nettype none
module atu_dp
  import atu_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_valid,
  input  wire logic [6:0] cfg_ack_target,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_item_t       out_data,
  input  wire cmd_t       cmd,
  output sts_t            sts
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  // Item and scan registers
  logic [1:0]    func_r;
  logic [31:0]   id_r;
  logic [PW-1:0] ptr_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_pos_r;
  logic          res_hit_r;
  logic [IW-1:0] res_pos_r;
  logic [31:0]   res_id_r;

  // Table counts and target
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] acked_r, acked_nxt;
  logic [6:0]    target_r;

  // Result register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // Memory ports
  logic [31:0]   rd_id;
  logic [0:0]    rd_flag;
  logic          id_we, flag_we;
  logic [IW-1:0] flag_waddr;

  logic issue_ok, hit, full, add_ok, ack_ok;
  logic [PW-1:0] need;

  atu_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_id_ram (
    .clk     (clk),
    .we      (id_we),
    .waddr   (held_r[IW-1:0]),
    .wdata   (id_r),
    .raddr   (ptr_r[IW-1:0]),
    .rdata_r (rd_id)
  );

  atu_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_flag_ram (
    .clk     (clk),
    .we      (flag_we),
    .waddr   (flag_waddr),
    .wdata   (ack_ok),
    .raddr   (ptr_r[IW-1:0]),
    .rdata_r (rd_flag)
  );

  // Scan: read at ptr each cycle, check last cycle's read
  assign issue_ok = (ptr_r < PW'(held_r));
  assign hit      = chk_v_r && !rd_flag[0] && ((func_r != FUNC_ACK) || (rd_id == id_r));

  assign sts.needs_scan = (in_data.func == FUNC_ACK) || (in_data.func == FUNC_FIND);
  assign sts.hit        = hit;
  assign sts.exhausted  = !chk_v_r && !issue_ok;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Table update at finish
  assign full       = (held_r == CW'(TABLE_DEPTH));
  assign add_ok     = (func_r == FUNC_ADD) && !full;
  assign ack_ok     = (func_r == FUNC_ACK) && res_hit_r;
  assign held_nxt   = held_r + CW'(add_ok);
  assign acked_nxt  = acked_r + CW'(ack_ok);
  assign id_we      = cmd.finish && add_ok;
  assign flag_we    = cmd.finish && (add_ok || ack_ok);
  assign flag_waddr = add_ok ? held_r[IW-1:0] : res_pos_r;

  assign need = (PW'(held_nxt) < PW'(target_r)) ? PW'(held_nxt) : PW'(target_r);

  // Result fields
  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt.status      = STS_NONE;
    out_data_nxt.acked_count = 7'(acked_nxt);
    out_data_nxt.entry_count = 7'(held_nxt);
    out_data_nxt.done_res    = (PW'(acked_nxt) >= need);
    if (func_r == FUNC_ADD) begin
      if (full) begin
        out_data_nxt.status = STS_FULL;
      end else begin
        out_data_nxt.status    = STS_OK;
        out_data_nxt.entry_pos = 6'(held_r);
        out_data_nxt.entry_id  = id_r;
      end
    end else if (res_hit_r) begin
      out_data_nxt.status    = STS_OK;
      out_data_nxt.entry_pos = 6'(res_pos_r);
      out_data_nxt.entry_id  = res_id_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      acked_r     <= '0;
      target_r    <= ACK_TARGET_RESET;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      res_hit_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target_r <= cfg_ack_target;
      end
      if (cmd.load) begin
        chk_v_r   <= 1'b0;
        res_hit_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_v_r <= issue_ok;
      end
      if (cmd.capture) begin
        res_hit_r <= hit;
      end
      if (cmd.finish) begin
        held_r      <= held_nxt;
        acked_r     <= acked_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      id_r   <= in_data.msg_id;
      ptr_r  <= (in_data.func == FUNC_FIND) ? PW'(in_data.start_pos) : '0;
    end else if (cmd.scan_step && issue_ok) begin
      ptr_r <= ptr_r + PW'(1);
    end
    if (cmd.scan_step) begin
      chk_pos_r <= ptr_r[IW-1:0];
    end
    if (cmd.capture) begin
      res_pos_r <= chk_pos_r;
      res_id_r  <= rd_id;
    end
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/ack_tracking_table_unit.sv @@
`default_nettype none
// Add and unused codes go straight from taking the item to loading the result;
// ack and find first read one table entry per cycle, stopping at the first hit or
// after the last entry, then load the result; a stalled result register holds the load.
// One item at a time: a new item is taken only once the last result is loaded.
// Reset (rst_n, synchronous): table empty, counts zero, ack target 20.
// Table contents are not cleared; only entries below the entry count are read.
module ack_tracking_table_unit
  import atu_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_ack_target
);

  cmd_t cmd;
  sts_t sts;

  // Target register takes writes at any time
  assign cfg_ready = 1'b1;

  atu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  atu_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .cfg_valid      (cfg_valid),
    .cfg_ack_target (cfg_ack_target),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import atu_pkg::*;

  localparam int TB_DEPTH = DEPTH_DEFAULT;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int DRAIN_CYCLES = TB_DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 40;
  // Spare operation code: the block answers it without touching the table
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_ack_target = ACK_TARGET_RESET;

  // Expectation typed into a directed row, travels with the item
  logic row_typed = 1'b0;
  out_item_t row_want = '0;

  // Table model
  logic [31:0] tbl_id [TB_DEPTH];
  logic tbl_acked [TB_DEPTH];
  int n_entries = 0;
  int n_acked = 0;
  int ack_goal = ACK_TARGET_RESET;

  out_item_t awaited_results [$];
  out_item_t predicted;
  out_item_t got_item;
  out_item_t want_item;
  plan_row_t plan_rows [$];
  logic [6:0] goal_plan [6];

  int mismatch_count = 0;
  int items_taken = 0;
  int results_checked = 0;
  int status_seen [3] = '{0, 0, 0};
  int done_high_seen = 0;
  int settings_used = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int free_left = 0;

  ack_tracking_table_unit #(
    .TABLE_DEPTH(TB_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_ack_target(cfg_ack_target)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the table model and return the result it yields
  function automatic out_item_t predict_table_result(input in_item_t it);
    out_item_t r;
    int j;
    int need;
    bit hit;
    r = '0;
    r.status = STS_NONE;
    hit = 1'b0;
    case (it.func)
      FUNC_ADD: begin
        if (n_entries >= TB_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          tbl_id[n_entries] = it.msg_id;
          tbl_acked[n_entries] = 1'b0;
          r.status = STS_OK;
          r.entry_pos = 6'(n_entries);
          r.entry_id = it.msg_id;
          n_entries++;
        end
      end
      FUNC_ACK: begin
        // first entry still waiting with this id
        for (j = 0; j < n_entries && !hit; j++) begin
          if (!tbl_acked[j] && tbl_id[j] == it.msg_id) begin
            hit = 1'b1;
            tbl_acked[j] = 1'b1;
            n_acked++;
            r.status = STS_OK;
            r.entry_pos = 6'(j);
            r.entry_id = it.msg_id;
          end
        end
      end
      FUNC_FIND: begin
        for (j = int'(it.start_pos); j < n_entries && !hit; j++) begin
          if (!tbl_acked[j]) begin
            hit = 1'b1;
            r.status = STS_OK;
            r.entry_pos = 6'(j);
            r.entry_id = tbl_id[j];
          end
        end
      end
      default: ;
    endcase
    need = (n_entries < ack_goal) ? n_entries : ack_goal;
    r.acked_count = 7'(n_acked);
    r.entry_count = 7'(n_entries);
    r.done_res = (n_acked >= need);
    return r;
  endfunction

  // Random request, shaped to hit ids that are in the table
  function automatic in_item_t random_request();
    in_item_t it;
    int r;
    int k;
    int j;
    it.func = FUNC_FIND;
    it.msg_id = $urandom;
    it.start_pos = 7'($urandom_range(0, TB_DEPTH));
    r = $urandom_range(0, 99);
    if (r < 12) begin
      it.func = FUNC_ADD;
      if (n_entries > 0 && $urandom_range(0, 3) == 0) begin
        it.msg_id = tbl_id[$urandom_range(0, n_entries - 1)];
      end else if ($urandom_range(0, 9) == 0) begin
        it.msg_id = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
    end else if (r < 45) begin
      it.func = FUNC_ACK;
      if (n_entries > 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, n_entries - 1);
        // half the time walk on to an entry still waiting
        if ($urandom_range(0, 1)) begin
          for (j = 0; j < n_entries && tbl_acked[k]; j++) k = (k + 1) % n_entries;
        end
        it.msg_id = tbl_id[k];
      end
    end else if (r < 93) begin
      if ($urandom_range(0, 9) < 7) it.start_pos = 7'($urandom_range(0, n_entries));
    end else begin
      it.func = FUNC_SPARE;
    end
    return it;
  endfunction

  function automatic plan_row_t mk_row(input logic [1:0] f, input logic [31:0] id,
                                       input logic [6:0] sp, input bit typed,
                                       input logic [1:0] st, input logic [5:0] pos,
                                       input logic [31:0] eid, input logic [6:0] acked,
                                       input logic [6:0] cnt, input logic done);
    plan_row_t row;
    row.stim.func = f;
    row.stim.msg_id = id;
    row.stim.start_pos = sp;
    row.typed = typed;
    row.want.status = st;
    row.want.entry_pos = pos;
    row.want.entry_id = eid;
    row.want.acked_count = acked;
    row.want.entry_count = cnt;
    row.want.done_res = done;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_checked, name, got, want));
    end
  endtask

  // Present one item, hold it until taken
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Change the target only once all results are back
  task automatic write_target(input logic [6:0] goal);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_ack_target <= goal;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Result-side stall pattern
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      free_left = $urandom_range(1, 8);
      out_stall <= 1'b0;
    end
  end

  // Track config writes, predict taken items, check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) ack_goal = int'(cfg_ack_target);
      if (in_valid && !in_stall) begin
        predicted = predict_table_result(in_data);
        awaited_results.push_back(row_typed ? row_want : predicted);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        got_item = out_data;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", got_item));
        end else begin
          want_item = awaited_results.pop_front();
          compare_field("status", got_item.status, want_item.status);
          compare_field("entry_pos", got_item.entry_pos, want_item.entry_pos);
          compare_field("entry_id", got_item.entry_id, want_item.entry_id);
          compare_field("acked_count", got_item.acked_count, want_item.acked_count);
          compare_field("entry_count", got_item.entry_count, want_item.entry_count);
          compare_field("done_res", got_item.done_res, want_item.done_res);
        end
        if (got_item.status <= STS_NONE) status_seen[got_item.status]++;
        if (got_item.done_res) done_high_seen++;
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Directed rows run with the reset target of 20
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd0, 1, STS_NONE, 0, 0, 0, 0, 1));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'h0, 7'd0, 1, STS_NONE, 0, 0, 0, 0, 1));
    plan_rows.push_back(mk_row(FUNC_SPARE, 32'hFFFF_FFFF, 7'd64, 1, STS_NONE, 0, 0, 0, 0, 1));
    plan_rows.push_back(mk_row(FUNC_ADD, 32'h0, 7'd0, 1, STS_OK, 0, 32'h0, 0, 1, 0));
    plan_rows.push_back(mk_row(FUNC_ADD, 32'hFFFF_FFFF, 7'd0, 1,
                               STS_OK, 1, 32'hFFFF_FFFF, 0, 2, 0));
    // duplicate id
    plan_rows.push_back(mk_row(FUNC_ADD, 32'hFFFF_FFFF, 7'd64, 1,
                               STS_OK, 2, 32'hFFFF_FFFF, 0, 3, 0));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'hFFFF_FFFF, 7'd0, 1,
                               STS_OK, 1, 32'hFFFF_FFFF, 1, 3, 0));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'hFFFF_FFFF, 7'd0, 1,
                               STS_OK, 2, 32'hFFFF_FFFF, 2, 3, 0));
    // every copy already acked
    plan_rows.push_back(mk_row(FUNC_ACK, 32'hFFFF_FFFF, 7'd0, 1, STS_NONE, 0, 0, 2, 3, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd0, 1, STS_OK, 0, 32'h0, 2, 3, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd1, 1, STS_NONE, 0, 0, 2, 3, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'hFFFF_FFFF, 7'd64, 1, STS_NONE, 0, 0, 2, 3, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd3, 1, STS_NONE, 0, 0, 2, 3, 0));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'h0, 7'd0, 1, STS_OK, 0, 32'h0, 3, 3, 1));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd0, 1, STS_NONE, 0, 0, 3, 3, 1));
    plan_rows.push_back(mk_row(FUNC_SPARE, 32'h0, 7'd0, 1, STS_NONE, 0, 0, 3, 3, 1));
    plan_rows.push_back(mk_row(FUNC_ADD, 32'h8000_0001, 7'd0, 0, STS_OK, 0, 0, 0, 0, 0));
    plan_rows.push_back(mk_row(FUNC_ADD, 32'h7FFF_FFFE, 7'd0, 0, STS_OK, 0, 0, 0, 0, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd2, 0, STS_OK, 0, 0, 0, 0, 0));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'h7FFF_FFFE, 7'd0, 0, STS_OK, 0, 0, 0, 0, 0));
    plan_rows.push_back(mk_row(FUNC_ACK, 32'h1234_5678, 7'd0, 0, STS_OK, 0, 0, 0, 0, 0));
    plan_rows.push_back(mk_row(FUNC_FIND, 32'h0, 7'd63, 0, STS_OK, 0, 0, 0, 0, 0));

    // Target settings for the random phases, extremes included
    goal_plan[0] = 7'd0;
    goal_plan[1] = 7'd127;
    goal_plan[2] = 7'd64;
    goal_plan[3] = 7'd1;
    goal_plan[4] = 7'($urandom_range(2, 63));
    goal_plan[5] = ACK_TARGET_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_rows[i]) send_item(plan_rows[i].stim, plan_rows[i].typed, plan_rows[i].want);

    foreach (goal_plan[p]) begin
      write_target(goal_plan[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 100 == 0) quiet = ($urandom_range(0, 4) == 0);
        send_item(random_request(), 1'b0, '0);
      end
    end

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items over %0d target settings; statuses ok/full/none %0d/%0d/%0d",
             items_taken, settings_used, status_seen[0], status_seen[1], status_seen[2]);
    $display("Table held %0d entries, %0d acknowledged; done flag high in %0d of %0d results",
             n_entries, n_acked, done_high_seen, results_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
